>>> rtl/xor_checked_frame_deframer_defines.svh
// Assertion helpers for the frame deframer checks.
`ifndef XOR_CHECKED_FRAME_DEFRAMER_DEFINES_SVH
`define XOR_CHECKED_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define XCFD_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("xcfd: check failed");

// next-cycle implication
`define XCFD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("xcfd: check failed");

`endif

>>> rtl/xcfd_pkg.sv
package xcfd_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_HDR1   = 2'd0;
  localparam logic [1:0] REG_HDR2   = 2'd1;
  localparam logic [1:0] REG_MAXLEN = 2'd2;

  localparam logic [7:0] HDR1_RST   = 8'hAA;
  localparam logic [7:0] HDR2_RST   = 8'h55;
  localparam logic [6:0] MAXLEN_RST = 7'd64;

  // one good frame handed from the parser to the drain side
  typedef struct packed {
    logic [7:0] cmd;
    logic [6:0] len;
    logic       bank;
  } desc_t;

  // payload buffer write port
  typedef struct packed {
    logic       en;
    logic       bank;
    logic [5:0] addr;
    logic [7:0] data;
  } wr_t;

endpackage

>>> rtl/xcfd_fifo.sv
module xcfd_fifo
  import xcfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  desc_t      din,
  input  logic       pop,
  output desc_t      dout,
  output logic       empty,
  output logic [1:0] count
);

  localparam int DEPTH = 2;

  desc_t      entries [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;

  assign dout  = entries[rd_ptr];
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

>>> rtl/xcfd_parse.sv
module xcfd_parse
  import xcfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] hdr1,
  input  logic [7:0] hdr2,
  input  logic [6:0] max_len,
  input  logic       full,
  output logic       push,
  output desc_t      push_desc,
  output wr_t        wr
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_LENH = 3'd3;
  localparam logic [2:0] PH_LENL = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;
  localparam logic [2:0] PH_CSUM = 3'd6;

  localparam logic [6:0] MAX_LIM = 7'(MAX_PAYLOAD);

  logic [2:0] phase;
  logic       bank;
  logic [7:0] cmd;
  logic       len_hi_nz;
  logic [6:0] len;
  logic [6:0] pos;
  logic [7:0] xr;

  logic       accept;
  logic [6:0] limit;
  logic [6:0] pos_inc;

  // payload bytes and the final push both need a free buffer bank
  assign in_ready = !(((phase == PH_DATA) || (phase == PH_CSUM)) && full);
  assign accept   = in_valid && in_ready;
  assign limit    = (max_len > MAX_LIM) ? MAX_LIM : max_len;
  assign pos_inc  = pos + 7'd1;

  assign wr.en   = accept && (phase == PH_DATA);
  assign wr.bank = bank;
  assign wr.addr = pos[5:0];
  assign wr.data = rx_byte;

  assign push           = accept && (phase == PH_CSUM) && (rx_byte == xr);
  assign push_desc.cmd  = cmd;
  assign push_desc.len  = len;
  assign push_desc.bank = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bank  <= 1'b0;
    end else if (accept) begin
      unique case (phase)
        PH_IDLE: begin
          if (rx_byte == hdr1) begin
            phase <= PH_HDR2;
          end
        end
        PH_HDR2: phase <= (rx_byte == hdr2) ? PH_CMD : PH_IDLE;
        PH_CMD:  phase <= PH_LENH;
        PH_LENH: phase <= PH_LENL;
        PH_LENL: begin
          if (!len_hi_nz && (rx_byte == 8'd0)) begin
            phase <= PH_CSUM;
          end else if (len_hi_nz || (rx_byte > {1'b0, limit})) begin
            phase <= PH_IDLE;
          end else begin
            phase <= PH_DATA;
          end
        end
        PH_DATA: begin
          if (pos_inc >= len) begin
            phase <= PH_CSUM;
          end
        end
        PH_CSUM: begin
          phase <= PH_IDLE;
          if (push) begin
            bank <= ~bank;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (phase)
        PH_CMD: begin
          cmd <= rx_byte;
          xr  <= rx_byte;
        end
        PH_LENH: begin
          len_hi_nz <= (rx_byte != 8'd0);
          xr        <= xr ^ rx_byte;
        end
        PH_LENL: begin
          len <= rx_byte[6:0];
          pos <= 7'd0;
          xr  <= xr ^ rx_byte;
        end
        PH_DATA: begin
          pos <= pos_inc;
          xr  <= xr ^ rx_byte;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/xcfd_drain.sv
module xcfd_drain
  import xcfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  wr_t        wr,
  input  desc_t      desc,
  input  logic       desc_empty,
  output logic       pop,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_command,
  output logic [6:0] frame_length,
  output logic       has_payload,
  output logic [7:0] payload_byte,
  output logic [5:0] payload_index,
  output logic       last_of_frame
);

  localparam int IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int MEM_DEPTH = 2 ** (IDX_W + 1);

  logic [7:0] mem [MEM_DEPTH];

  desc_t      cur;
  logic [5:0] cnt;
  logic       advance;
  logic       issue_last;

  // read stage
  logic       a_valid;
  logic [7:0] a_cmd;
  logic [6:0] a_len;
  logic       a_has;
  logic [5:0] a_idx;
  logic       a_last;
  logic [7:0] a_data;

  assign advance    = !out_valid || out_ready;
  assign issue_last = (cur.len == 7'd0) || (({1'b0, cnt} + 7'd1) == cur.len);
  assign pop        = !busy && !desc_empty;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.addr[IDX_W-1:0]}] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_data <= mem[{cur.bank, cnt[IDX_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (busy && advance && issue_last) begin
        // bank is free once its last byte has been read
        busy <= 1'b0;
      end
      if (advance) begin
        a_valid   <= busy;
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= desc;
      cnt <= 6'd0;
    end else if (busy && advance) begin
      cnt <= cnt + 6'd1;
    end
    if (advance) begin
      a_cmd         <= cur.cmd;
      a_len         <= cur.len;
      a_has         <= (cur.len != 7'd0);
      a_idx         <= cnt;
      a_last        <= issue_last;
      frame_command <= a_cmd;
      frame_length  <= a_len;
      has_payload   <= a_has;
      payload_byte  <= a_has ? a_data : 8'd0;
      payload_index <= a_has ? a_idx : 6'd0;
      last_of_frame <= a_last;
    end
  end

endmodule

>>> rtl/xor_checked_frame_deframer.sv
// Byte-stream frame deframer: sync1, sync2, command, 16-bit big-endian length,
// payload, XOR checksum over command, length and payload. One rx_byte request
// is taken per cycle. A frame with a good checksum yields one result per
// payload byte (or one empty result for a zero-length frame), last one marked;
// the first result is offered after the descriptor FIFO, the drain's current
// frame register, its read stage and its output register; the run then streams
// one result per cycle while out_ready is high. Payload is held in a two-bank
// buffer, so a frame can be received while the previous one drains; payload
// and checksum bytes stall (rx ready low) only while both banks hold frames not
// yet drained. Registers (APB, byte address 4*i): 0 first header, 1 second
// header, 2 max payload length (values above MAX_PAYLOAD act as MAX_PAYLOAD).
module xor_checked_frame_deframer
  import xcfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic [7:0]        rx_byte,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        frame_command,
  output logic [6:0]        frame_length,
  output logic              has_payload,
  output logic [7:0]        payload_byte,
  output logic [5:0]        payload_index,
  output logic              last_of_frame
);

  logic [7:0] hdr1;
  logic [7:0] hdr2;
  logic [6:0] max_len;

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  logic       push;
  desc_t      push_desc;
  wr_t        wr;
  desc_t      desc;
  logic       desc_empty;
  logic [1:0] desc_count;
  logic       pop;
  logic       busy;
  logic [1:0] outstanding;
  logic       full;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr1    <= HDR1_RST;
      hdr2    <= HDR2_RST;
      max_len <= MAXLEN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HDR1:   hdr1    <= pwdata[7:0];
        REG_HDR2:   hdr2    <= pwdata[7:0];
        REG_MAXLEN: max_len <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HDR1:   prdata = {24'd0, hdr1};
      REG_HDR2:   prdata = {24'd0, hdr2};
      REG_MAXLEN: prdata = {25'd0, max_len};
      default:    prdata = '0;
    endcase
  end

  // frames queued plus the one being read out, one buffer bank each
  assign outstanding = desc_count + {1'b0, busy};
  assign full        = (outstanding >= 2'd2);

  xcfd_parse #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .hdr1      (hdr1),
    .hdr2      (hdr2),
    .max_len   (max_len),
    .full      (full),
    .push      (push),
    .push_desc (push_desc),
    .wr        (wr)
  );

  xcfd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_desc),
    .pop   (pop),
    .dout  (desc),
    .empty (desc_empty),
    .count (desc_count)
  );

  xcfd_drain #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_drain (
    .clk           (clk),
    .rst           (rst),
    .wr            (wr),
    .desc          (desc),
    .desc_empty    (desc_empty),
    .pop           (pop),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_command (frame_command),
    .frame_length  (frame_length),
    .has_payload   (has_payload),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .last_of_frame (last_of_frame)
  );

endmodule

>>> rtl/xcfd_check.sv
`include "xor_checked_frame_deframer_defines.svh"

module xcfd_check (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] frame_command,
  input logic [6:0] frame_length,
  input logic       has_payload,
  input logic [7:0] payload_byte,
  input logic [5:0] payload_index,
  input logic       last_of_frame
);

  // stalled result holds
  `XCFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_command) && $stable(payload_byte) && $stable(payload_index) && $stable(last_of_frame))

  // empty frame result is a lone, marked item with zero length, byte and index
  `XCFD_ASSERT_IMPL(a_empty_shape, out_valid && !has_payload, last_of_frame && (payload_byte == 8'd0) && (payload_index == 6'd0) && (frame_length == 7'd0))

  // payload index stays inside the frame
  `XCFD_ASSERT_IMPL(a_idx_range, out_valid && has_payload, {1'b0, payload_index} < frame_length)

  // last marker exactly on the final payload byte
  `XCFD_ASSERT_IMPL(a_last_pos, out_valid && has_payload, last_of_frame == (({1'b0, payload_index} + 7'd1) == frame_length))

endmodule

bind xor_checked_frame_deframer xcfd_check u_check (.*);

>>> tb/tb_top.sv
module tb_top;
  import xcfd_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // no register behind this address
  localparam int HOLD_CYCLES = 500;

  typedef enum logic [2:0] {
    PS_IDLE, PS_SYNC2, PS_CMD, PS_LEN_HI, PS_LEN_LO, PS_DATA, PS_CSUM
  } parse_state_t;

  typedef struct {
    logic [7:0] cmd;
    logic [6:0] len;
    logic       has_data;
    logic [7:0] data;
    logic [5:0] idx;
    logic       last;
  } frame_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic [7:0]        rx_byte = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        frame_command;
  logic [6:0]        frame_length;
  logic              has_payload;
  logic [7:0]        payload_byte;
  logic [5:0]        payload_index;
  logic              last_of_frame;

  xor_checked_frame_deframer i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .rx_byte      (rx_byte),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_command(frame_command),
    .frame_length (frame_length),
    .has_payload  (has_payload),
    .payload_byte (payload_byte),
    .payload_index(payload_index),
    .last_of_frame(last_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies
  logic [7:0] cfg_hdr1 = HDR1_RST;
  logic [7:0] cfg_hdr2 = HDR2_RST;
  logic [6:0] cfg_maxlen = MAXLEN_RST;

  // parser copy
  parse_state_t parse_st = PS_IDLE;
  logic [7:0]   cur_cmd = '0;
  logic [15:0]  cur_len = '0;
  logic [6:0]   data_pos = '0;
  logic [7:0]   xsum = '0;
  logic [7:0]   payload_mem [64];

  logic [7:0]    rx_pending[$];
  frame_result_t awaited_results[$];
  int            err_count = 0;

  int sender_gaps = 1;
  int burst_left = 0;
  int pause_left = 0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;
  int ready_pct = 100;
  int mode_left = 0;

  function automatic int length_limit();
    return (cfg_maxlen > 64) ? 64 : int'(cfg_maxlen);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    frame_result_t r;
    int n;
    case (parse_st)
      PS_IDLE: if (b == cfg_hdr1) parse_st = PS_SYNC2;
      PS_SYNC2: parse_st = (b == cfg_hdr2) ? PS_CMD : PS_IDLE;
      PS_CMD: begin
        cur_cmd = b;
        xsum = b;
        parse_st = PS_LEN_HI;
      end
      PS_LEN_HI: begin
        cur_len = {b, 8'h00};
        xsum ^= b;
        parse_st = PS_LEN_LO;
      end
      PS_LEN_LO: begin
        cur_len[7:0] = b;
        xsum ^= b;
        data_pos = '0;
        if (cur_len == 0) parse_st = PS_CSUM;
        else if (cur_len > length_limit()) parse_st = PS_IDLE;
        else parse_st = PS_DATA;
      end
      PS_DATA: begin
        if (data_pos < 64) payload_mem[data_pos[5:0]] = b;
        data_pos = data_pos + 7'd1;
        xsum ^= b;
        if (data_pos >= cur_len) parse_st = PS_CSUM;
      end
      PS_CSUM: begin
        if (b == xsum) begin
          n = (cur_len > 64) ? 64 : int'(cur_len);
          if (n == 0) begin
            r = '{cmd: cur_cmd, len: '0, has_data: 1'b0, data: '0, idx: '0, last: 1'b1};
            awaited_results.push_back(r);
          end else begin
            for (int i = 0; i < n; i++) begin
              r.cmd = cur_cmd;
              r.len = n[6:0];
              r.has_data = 1'b1;
              r.data = payload_mem[i];
              r.idx = i[5:0];
              r.last = (i == n - 1);
              awaited_results.push_back(r);
            end
          end
        end
        parse_st = PS_IDLE;
      end
      default: parse_st = PS_IDLE;
    endcase
  endfunction

  // sender: bursts of random length, random pauses between them while sender_gaps is set
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) deframe_byte(rx_byte);
      if (!in_valid || in_ready) begin
        if (pause_left > 0) begin
          pause_left--;
          in_valid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          rx_byte <= rx_pending.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            pause_left = (sender_gaps != 0 && $urandom_range(0, 1)) ? $urandom_range(1, 8) : 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random ready with a drifting duty, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 96);
        case ($urandom_range(0, 4))
          0, 1: ready_pct = 100;
          2: ready_pct = 75;
          3: ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end else begin
        mode_left--;
      end
      out_ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    frame_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: command %0d index %0d", frame_command, payload_index);
        err_count++;
      end else begin
        e = awaited_results.pop_front();
        if (frame_command !== e.cmd) begin
          $error("frame_command: expected %0d, got %0d", e.cmd, frame_command);
          err_count++;
        end
        if (frame_length !== e.len) begin
          $error("frame_length: expected %0d, got %0d", e.len, frame_length);
          err_count++;
        end
        if (has_payload !== e.has_data) begin
          $error("has_payload: expected %0d, got %0d", e.has_data, has_payload);
          err_count++;
        end
        if (payload_byte !== e.data) begin
          $error("payload_byte: expected %0d, got %0d", e.data, payload_byte);
          err_count++;
        end
        if (payload_index !== e.idx) begin
          $error("payload_index: expected %0d, got %0d", e.idx, payload_index);
          err_count++;
        end
        if (last_of_frame !== e.last) begin
          $error("last_of_frame: expected %0d, got %0d", e.last, last_of_frame);
          err_count++;
        end
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HDR1: cfg_hdr1 = data[7:0];
      REG_HDR2: cfg_hdr2 = data[7:0];
      REG_MAXLEN: cfg_maxlen = data[6:0];
      default: ;
    endcase
  endtask

  // read back one register, checked at the access edge
  task automatic apb_check(input logic [1:0] idx, input logic [31:0] exp_val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== exp_val) begin
      $error("prdata: expected %0d, got %0d", exp_val, prdata);
      err_count++;
    end
    if (pready !== 1'b1) begin
      $error("pready: expected %0d, got %0d", 1'b1, pready);
      err_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper pwdata bits are random and must be dropped by the block
  task automatic set_regs(input logic [7:0] h1, input logic [7:0] h2, input logic [6:0] ml);
    apb_write(REG_HDR1, {24'($urandom_range(0, 16777215)), h1});
    apb_write(REG_HDR2, {24'($urandom_range(0, 16777215)), h2});
    apb_write(REG_MAXLEN, {25'($urandom()), ml});
    apb_check(REG_HDR1, {24'd0, h1});
    apb_check(REG_HDR2, {24'd0, h2});
    apb_check(REG_MAXLEN, {25'd0, ml});
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (rx_pending.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input int n_data, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] d;
    sum = cmd ^ len[15:8] ^ len[7:0];
    rx_pending.push_back(cfg_hdr1);
    rx_pending.push_back(cfg_hdr2);
    rx_pending.push_back(cmd);
    rx_pending.push_back(len[15:8]);
    rx_pending.push_back(len[7:0]);
    repeat (n_data) begin
      d = 8'($urandom_range(0, 255));
      sum ^= d;
      rx_pending.push_back(d);
    end
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    rx_pending.push_back(sum);
  endtask

  task automatic queue_random_frame();
    int kind;
    int lim;
    int len;
    logic [7:0] b;
    lim = length_limit();
    kind = $urandom_range(0, 99);
    len = (lim > 8 && $urandom_range(0, 9) == 0) ? $urandom_range(0, lim)
                                                  : $urandom_range(0, (lim < 8) ? lim : 8);
    if (kind < 65) begin
      push_frame(8'($urandom_range(0, 255)), 16'(len), len, 1'b0);
    end else if (kind < 75) begin
      push_frame(8'($urandom_range(0, 255)), 16'(len), len, 1'b1);
    end else if (kind < 83) begin
      // too long: dropped right after the length bytes
      len = $urandom_range(0, 1) ? $urandom_range(lim + 1, 65535) : lim + 1;
      push_frame(8'($urandom_range(0, 255)), 16'(len), $urandom_range(0, 3), 1'b0);
    end else if (kind < 91) begin
      b = 8'($urandom_range(0, 255));
      if (b == cfg_hdr2) b ^= 8'h01;
      rx_pending.push_back(cfg_hdr1);
      rx_pending.push_back(b);
    end else begin
      repeat ($urandom_range(1, 4)) rx_pending.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int n_bytes);
    while (rx_pending.size() < n_bytes) queue_random_frame();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset register values
    push_frame(8'h00, 16'd0, 0, 1'b0);
    push_frame(8'hFF, 16'd1, 1, 1'b0);
    push_frame(8'h5A, 16'd3, 3, 1'b1);
    rx_pending.push_back(cfg_hdr1);
    rx_pending.push_back(cfg_hdr2 ^ 8'h01);
    push_frame(8'h01, 16'hFFFF, 2, 1'b0);
    push_frame(8'h02, 16'd65, 1, 1'b0);
    push_frame(8'h80, 16'd2, 2, 1'b0);
    wait_drained();

    // only empty frames pass
    apb_write(REG_SPARE, $urandom());
    set_regs(8'h00, 8'hFF, 7'd0);
    push_frame(8'h33, 16'd0, 0, 1'b0);
    push_frame(8'h34, 16'd1, 1, 1'b0);
    run_random(30);
    wait_drained();

    // limit above the buffer size acts as the buffer size
    set_regs(8'hFF, 8'h00, 7'd127);
    push_frame(8'hC3, 16'd64, 64, 1'b0);
    push_frame(8'hC4, 16'd65, 2, 1'b0);
    run_random(80);
    wait_drained();

    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 7'd1);
    push_frame(8'h11, 16'd1, 1, 1'b0);
    push_frame(8'h12, 16'd2, 2, 1'b0);
    run_random(25);
    wait_drained();

    // receiver holds off while frames keep coming, so both banks fill
    set_regs(HDR1_RST, HDR2_RST, MAXLEN_RST);
    sender_gaps = 0;
    hold_req = ~hold_req;
    repeat (6) push_frame(8'($urandom_range(0, 255)), 16'd10, 10, 1'b0);
    wait_drained();
    sender_gaps = 1;
    push_frame(8'h77, 16'd64, 64, 1'b0);
    run_random(75);
    wait_drained();

    sender_gaps = 0;
    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             7'($urandom_range(0, 127)));
    run_random(30);
    wait_drained();
    repeat (30) @(posedge clk);

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
